FILE: hw/rtl/cprs_pkg.sv
// ----------------------------------------------------------------------------
// cprs_pkg: shared types and constants for the complex pixel select unit
// Mode codes, angle format, arctangent table and gain constant used by the
// CORDIC cells and the output stage.
// ----------------------------------------------------------------------------
package cprs_pkg;

	localparam int OUT_W      = 17;
	localparam int ZW         = 34;
	localparam int FRAC_BITS  = 16;
	localparam int ATAN_LEN   = 32;
	localparam int GAIN_W     = 24;

	typedef logic signed [ZW-1:0]    z_t;
	typedef logic signed [OUT_W-1:0] out_t;

	typedef enum logic [1:0] {
		MODE_MAG   = 2'd0,
		MODE_REAL  = 2'd1,
		MODE_IMAG  = 2'd2,
		MODE_PHASE = 2'd3
	} mode_t;

	// per-transaction side information carried next to the rotator data
	typedef struct packed {
		logic  last;
		mode_t mode;
		logic  zero;
		out_t  copy;
	} side_t;

	// atan(2^-k), pi = 2^31
	localparam z_t ATAN_TAB [ATAN_LEN] = '{
		34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
		34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
		34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
		34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
		34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
		34'sd652,       34'sd326,       34'sd163,       34'sd81,
		34'sd41,        34'sd20,        34'sd10,        34'sd5,
		34'sd3,         34'sd1,         34'sd1,         34'sd0
	};

	localparam z_t PI_ANGLE = 34'sd2147483648;

	// 0.6072529 in Q.24
	localparam logic [GAIN_W-1:0] GAIN_Q24 = 24'd10188014;

	localparam int MAG_MAX = 65535;

endpackage

FILE: hw/rtl/cprs_cell.sv
// ----------------------------------------------------------------------------
// cprs_cell: one CORDIC vectoring micro-rotation
// Rotates (x, y) by +/- atan(2^-K) toward the x axis, accumulates the angle
// and registers the result with its own valid/ready handshake.
// ----------------------------------------------------------------------------
module cprs_cell import cprs_pkg::*; #(
	parameter int XW = 35,
	parameter int K  = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [XW-1:0] in_x,
	input  logic signed [XW-1:0] in_y,
	input  z_t                   in_z,
	input  side_t                in_side,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [XW-1:0] out_x,
	output logic signed [XW-1:0] out_y,
	output z_t                   out_z,
	output side_t                out_side
);

	logic                 valid_q;
	logic signed [XW-1:0] x_q, y_q;
	z_t                   z_q;
	side_t                side_q;

	logic signed [XW-1:0] dx, dy, x_d, y_d;
	z_t                   z_d;

	// arithmetic shift rounds toward minus infinity
	assign dx = in_y >>> K;
	assign dy = in_x >>> K;

	always_comb begin
		if (in_y[XW-1]) begin
			x_d = in_x - dx;
			y_d = in_y + dy;
			z_d = in_z - ATAN_TAB[K];
		end else begin
			x_d = in_x + dx;
			y_d = in_y - dy;
			z_d = in_z + ATAN_TAB[K];
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x_q    <= x_d;
			y_q    <= y_d;
			z_q    <= z_d;
			side_q <= in_side;
		end
	end

	assign out_valid = valid_q;
	assign out_x     = x_q;
	assign out_y     = y_q;
	assign out_z     = z_q;
	assign out_side  = side_q;

endmodule

FILE: hw/rtl/cprs_post.sv
// ----------------------------------------------------------------------------
// cprs_post: gain correction, phase rounding and result select
// Two registered stages: partial products and phase in the first, the
// rounded magnitude sum and mode select in the second, which is the output.
// ----------------------------------------------------------------------------
module cprs_post import cprs_pkg::*; #(
	parameter int XW = 35
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [XW-1:0] in_x,
	input  z_t                   in_z,
	input  side_t                in_side,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_t                 pixel_value,
	output logic                 last_out
);

	localparam int HW   = XW - FRAC_BITS;
	localparam int PHW  = HW + GAIN_W;
	localparam int PLW  = FRAC_BITS + GAIN_W;
	localparam int AW   = PHW + 1;
	localparam int ZSW  = ZW - FRAC_BITS;

	localparam logic signed [ZSW-1:0] PH_MAX = ZSW'(32768);
	localparam logic signed [ZSW-1:0] PH_MIN = -(ZSW'(32768));

	// stage 1
	logic           valid_s1;
	logic [PHW-1:0] prod_hi_s1;
	logic [PLW-1:0] prod_lo_s1;
	out_t           phase_s1;
	side_t          side_s1;

	// stage 2
	logic           valid_s2;
	out_t           value_s2;
	logic           last_s2;

	logic                 ready_s2;
	logic [XW-1:0]        ux;
	logic [HW-1:0]        hi;
	logic [FRAC_BITS-1:0] lo;
	z_t                   z_rnd;
	logic signed [ZSW-1:0] ph_full;
	out_t                 phase_d;
	logic [AW-1:0]        acc;
	logic [63:0]          mag_full;
	out_t                 mag;
	out_t                 value_d;

	assign ux = in_x[XW-1] ? '0 : in_x;
	assign hi = ux[XW-1:FRAC_BITS];
	assign lo = ux[FRAC_BITS-1:0];

	assign z_rnd   = in_z + ZW'(32768);
	assign ph_full = z_rnd[ZW-1:FRAC_BITS];

	always_comb begin
		priority if (ph_full > PH_MAX) begin
			phase_d = OUT_W'(32768);
		end else if (ph_full < PH_MIN) begin
			phase_d = -(OUT_W'(32768));
		end else begin
			phase_d = OUT_W'(ph_full);
		end
	end

	assign ready_s2 = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			prod_hi_s1 <= PHW'(hi) * PHW'(GAIN_Q24);
			prod_lo_s1 <= PLW'(lo) * PLW'(GAIN_Q24);
			phase_s1   <= phase_d;
			side_s1    <= in_side;
		end
	end

	// round half up, then drop the Q.24 fraction
	assign acc = AW'(prod_hi_s1) + AW'(prod_lo_s1[PLW-1:FRAC_BITS])
		+ AW'(1 << (GAIN_W - 1));
	assign mag_full = 64'(acc[AW-1:GAIN_W]);
	assign mag = (mag_full > 64'(MAG_MAX)) ? OUT_W'(MAG_MAX) : OUT_W'(mag_full);

	always_comb begin
		unique case (side_s1.mode)
			MODE_MAG:   value_d = mag;
			MODE_REAL:  value_d = side_s1.copy;
			MODE_IMAG:  value_d = side_s1.copy;
			MODE_PHASE: value_d = side_s1.zero ? '0 : phase_s1;
			default:    value_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			value_s2 <= value_d;
			last_s2  <= side_s1.last;
		end
	end

	assign out_valid   = valid_s2;
	assign pixel_value = value_s2;
	assign last_out    = last_s2;

endmodule

FILE: hw/rtl/complex_pixel_to_real_select_unit.sv
// Converts a stream of complex pixels into real values, one transaction per
// clock when the output side keeps up. The mode register picks magnitude,
// real part, imaginary part or phase (pi = 32768; zero when both parts are
// zero). Magnitude and phase come from a CORDIC built as a chain of
// CORDIC_STAGES rotation cells followed by two gain/select stages; every cell
// holds a register, so up to CORDIC_STAGES + 2 pixels are in flight and a
// stalled output does not stop acceptance until the chain is full. Write the
// mode register only while the block is idle.

// ----------------------------------------------------------------------------
// complex_pixel_to_real_select_unit: complex pixel to real value converter
// Top level: mode register, vector pre-rotation, cell chain and output stage.
// ----------------------------------------------------------------------------
module complex_pixel_to_real_select_unit import cprs_pkg::*; #(
	parameter int SAMPLE_WIDTH  = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [1:0]                     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] real_part,
	input  logic signed [SAMPLE_WIDTH-1:0] imag_part,
	input  logic                           last_pixel,
	output logic                           out_valid,
	input  logic                           out_ready,
	output out_t                           pixel_value,
	output logic                           last_out
);

	// Q.16 plus headroom for negation and CORDIC growth
	localparam int XW = SAMPLE_WIDTH + FRAC_BITS + 3;

	localparam logic signed [XW-1:0] COPY_MAX = XW'(65535);
	localparam logic signed [XW-1:0] COPY_MIN = -(XW'(65536));

	mode_t mode_q;

	logic signed [XW-1:0] re_w, im_w, re_x, im_x, re_c, im_c;
	logic signed [XW-1:0] x0, y0;
	z_t                   z0;
	side_t                side0;

	logic signed [XW-1:0] cx [CORDIC_STAGES+1];
	logic signed [XW-1:0] cy [CORDIC_STAGES+1];
	z_t                   cz [CORDIC_STAGES+1];
	side_t                cs [CORDIC_STAGES+1];
	logic                 cv [CORDIC_STAGES+1];
	logic                 cr [CORDIC_STAGES+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_MAG;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= mode_t'(cfg_data);
		end
	end

	assign re_w = XW'(real_part);
	assign im_w = XW'(imag_part);
	assign re_x = re_w <<< FRAC_BITS;
	assign im_x = im_w <<< FRAC_BITS;

	// left half plane: negate the vector and start from +/- pi
	always_comb begin
		if (real_part < 0) begin
			x0 = -re_x;
			y0 = -im_x;
			z0 = (imag_part < 0) ? -PI_ANGLE : PI_ANGLE;
		end else begin
			x0 = re_x;
			y0 = im_x;
			z0 = '0;
		end
	end

	always_comb begin
		priority if (re_w > COPY_MAX) begin
			re_c = COPY_MAX;
		end else if (re_w < COPY_MIN) begin
			re_c = COPY_MIN;
		end else begin
			re_c = re_w;
		end
		priority if (im_w > COPY_MAX) begin
			im_c = COPY_MAX;
		end else if (im_w < COPY_MIN) begin
			im_c = COPY_MIN;
		end else begin
			im_c = im_w;
		end
	end

	always_comb begin
		side0.last = last_pixel;
		side0.mode = mode_q;
		side0.zero = (real_part == '0) && (imag_part == '0);
		side0.copy = (mode_q == MODE_IMAG) ? OUT_W'(im_c) : OUT_W'(re_c);
	end

	assign cx[0]    = x0;
	assign cy[0]    = y0;
	assign cz[0]    = z0;
	assign cs[0]    = side0;
	assign cv[0]    = in_valid;
	assign in_ready = cr[0];

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
		cprs_cell #(
			.XW (XW),
			.K  (k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cv[k]),
			.in_ready  (cr[k]),
			.in_x      (cx[k]),
			.in_y      (cy[k]),
			.in_z      (cz[k]),
			.in_side   (cs[k]),
			.out_valid (cv[k+1]),
			.out_ready (cr[k+1]),
			.out_x     (cx[k+1]),
			.out_y     (cy[k+1]),
			.out_z     (cz[k+1]),
			.out_side  (cs[k+1])
		);
	end

	cprs_post #(
		.XW (XW)
	) u_post (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (cv[CORDIC_STAGES]),
		.in_ready    (cr[CORDIC_STAGES]),
		.in_x        (cx[CORDIC_STAGES]),
		.in_z        (cz[CORDIC_STAGES]),
		.in_side     (cs[CORDIC_STAGES]),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_value (pixel_value),
		.last_out    (last_out)
	);

endmodule

FILE: hw/rtl/cprs_checker.sv
// ----------------------------------------------------------------------------
// cprs_checker: port-level checks for the complex pixel select unit
// Tracks the mode register from configuration transactions and checks the
// output range in magnitude and phase modes, output hold under stall and the ready behavior.
// ----------------------------------------------------------------------------
module cprs_checker import cprs_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_valid,
	input logic       cfg_ready,
	input logic [1:0] cfg_data,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input out_t       pixel_value,
	input logic       last_out
);

	mode_t mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_MAG;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= mode_t'(cfg_data);
		end
	end

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_value) && $stable(last_out))
		else $error("output changed while stalled");

	// an empty output register means the whole chain can take a transaction
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input not ready while output is empty");

	a_mag_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_q == MODE_MAG |-> !pixel_value[OUT_W-1])
		else $error("negative magnitude");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_q == MODE_PHASE |->
			(pixel_value[OUT_W-1] == pixel_value[OUT_W-2]) ||
			(pixel_value == OUT_W'(32768)))
		else $error("phase out of range");

endmodule

bind complex_pixel_to_real_select_unit cprs_checker u_cprs_checker (.*);
